[sv/hbridge_duty_to_pwm_deadband_macros.svh]
// assertion helpers shared by the block
`ifndef HBRIDGE_DUTY_TO_PWM_DEADBAND_MACROS_SVH
`define HBRIDGE_DUTY_TO_PWM_DEADBAND_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HBDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HBDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hbdp_pkg.sv]
package hbdp_pkg;

  localparam int GAIN_W  = 17;
  localparam int DB_W    = 14;
  localparam int PWM_W   = 10;
  localparam int DUTY_W  = 16;
  localparam int CFG_W   = 17;
  localparam int CIDX_W  = 3;

  // Q0.14 full scale of the deadband, as the divisor base
  localparam logic [DB_W:0] DUTY_ONE = 15'd16384;

  localparam logic [GAIN_W-1:0] GAIN_LF_RST = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_LR_RST = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_RF_RST = 17'd62865;
  localparam logic [GAIN_W-1:0] GAIN_RR_RST = 17'd65208;
  localparam logic [DB_W-1:0]   DEADBAND_RST = 14'd819;
  localparam logic [PWM_W-1:0]  MIN_EFF_RST = 10'd35;

  typedef enum logic [CIDX_W-1:0] {
    REG_GAIN_LF  = 3'd0,
    REG_GAIN_LR  = 3'd1,
    REG_GAIN_RF  = 3'd2,
    REG_GAIN_RR  = 3'd3,
    REG_DEADBAND = 3'd4,
    REG_MIN_EFF  = 3'd5,
    REG_MAX_PWM  = 3'd6
  } cfg_reg_t;

endpackage

[sv/hbridge_duty_to_pwm_deadband.sv]
// H-bridge duty-to-pwm converter with deadband compensation. Each transaction on the
// in_ channel carries a motor select (in_cmd, 0 left, 1 right) and a signed Q2.14 duty
// (16384 is full forward). The duty is scaled by a Q1.16 gain picked by side and by the
// sign of the duty, clamped to plus or minus one and inverted. Magnitudes at or below
// the deadband give pwm 0 with both bridge inputs low (coast); beyond it the magnitude
// maps linearly from the minimum drive level to max_pwm, rounded half up and clamped to
// max_pwm. A positive inverted duty drives in1 low and in2 high, a negative one the
// reverse. Exactly one out_ transaction follows each in_ transaction, in order. The
// datapath is a 16-stage pipeline: one transaction can enter every clock when nothing
// stalls. The depth is set by the rounding division, a ten-stage restoring divider that
// settles one quotient bit per stage. Each stage holds its item while the stage after it
// is full and stalled, so empty stages keep filling while out_stall is high. Registers
// are written through the cfg_ port (cfg_ready is always high) and must only change
// while the pipeline is empty; one internal product of the config registers is
// registered, so it lags a write.
`include "hbridge_duty_to_pwm_deadband_macros.svh"

module hbridge_duty_to_pwm_deadband #(
  parameter int PWM_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic signed [hbdp_pkg::DUTY_W-1:0] in_duty,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_side,
  output logic                          out_drive_in1,
  output logic                          out_drive_in2,
  output logic [hbdp_pkg::PWM_W-1:0]    out_pwm_value,
  // register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hbdp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [hbdp_pkg::CFG_W-1:0]    cfg_data
);
  import hbdp_pkg::*;

  // stage map: 0..4 front end, 5..14 divider, 15 output register
  localparam int DIV_STEPS = PWM_W;
  localparam int FRONT     = 5;
  localparam int NSTAGE    = FRONT + DIV_STEPS + 1;
  localparam int N_W       = 24;   // scaled dividend, below divisor << DIV_STEPS
  localparam logic [PWM_W-1:0] MAX_PWM_RST = PWM_W'((1 << PWM_BITS) - 1);
  localparam logic signed [33:0] PROD_ONE  = 34'sh0_4000_0000;
  localparam logic signed [33:0] PROD_MONE = -34'sh0_4000_0000;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_lf_r, gain_lr_r, gain_rf_r, gain_rr_r;
  logic [DB_W-1:0]   deadband_r;
  logic [PWM_W-1:0]  min_eff_r, max_pwm_r;
  logic [24:0]       mind_r;      // min drive level * (1 - deadband), Q0.14 units
  logic [24:0]       mind_nxt;
  logic [DB_W:0]     den_q;       // 1 - deadband in Q0.14, 1..16384
  logic signed [10:0] span;       // max_pwm - min drive level

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_lf_r  <= GAIN_LF_RST;
      gain_lr_r  <= GAIN_LR_RST;
      gain_rf_r  <= GAIN_RF_RST;
      gain_rr_r  <= GAIN_RR_RST;
      deadband_r <= DEADBAND_RST;
      min_eff_r  <= MIN_EFF_RST;
      max_pwm_r  <= MAX_PWM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_LF:  gain_lf_r  <= cfg_data;
        REG_GAIN_LR:  gain_lr_r  <= cfg_data;
        REG_GAIN_RF:  gain_rf_r  <= cfg_data;
        REG_GAIN_RR:  gain_rr_r  <= cfg_data;
        REG_DEADBAND: deadband_r <= cfg_data[DB_W-1:0];
        REG_MIN_EFF:  min_eff_r  <= cfg_data[PWM_W-1:0];
        REG_MAX_PWM:  max_pwm_r  <= cfg_data[PWM_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign den_q    = DUTY_ONE - {1'b0, deadband_r};
  assign span     = $signed({1'b0, max_pwm_r}) - $signed({1'b0, min_eff_r});
  assign mind_nxt = {15'b0, min_eff_r} * {10'b0, den_q};

  // registered so the multiply stays off the datapath
  always_ff @(posedge clk) begin
    mind_r <= mind_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or its successor loads
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] en;

  assign en[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
  for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: gain select and duty * gain (exact Q.30)
  // ---------------------------------------------------------------------------
  logic                  duty_pos;
  logic [GAIN_W-1:0]     gain_sel;
  logic signed [33:0]    s1_prod_nxt, s1_prod_r;
  logic                  s1_side_r;

  assign duty_pos = !in_duty[DUTY_W-1] && (in_duty != '0);

  always_comb begin
    if (in_cmd) begin
      gain_sel = duty_pos ? gain_rf_r : gain_rr_r;
    end else begin
      gain_sel = duty_pos ? gain_lf_r : gain_lr_r;
    end
  end

  assign s1_prod_nxt = in_duty * $signed({1'b0, gain_sel});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_prod_r <= s1_prod_nxt;
      s1_side_r <= in_cmd;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: clamp to +-1, magnitude, deadband test
  // ---------------------------------------------------------------------------
  logic [33:0]  s1_neg;
  logic [30:0]  mag;
  logic [30:0]  db_q30;
  logic         s2_coast_nxt;
  logic [30:0]  s2_md_r;
  logic         s2_side_r, s2_pneg_r, s2_coast_r;

  assign s1_neg = 34'(-s1_prod_r);

  always_comb begin
    if (s1_prod_r > PROD_ONE || s1_prod_r < PROD_MONE) begin
      mag = 31'h4000_0000;
    end else if (s1_prod_r[33]) begin
      mag = s1_neg[30:0];
    end else begin
      mag = s1_prod_r[30:0];
    end
  end

  assign db_q30       = {1'b0, deadband_r, 16'b0};
  assign s2_coast_nxt = (mag <= db_q30);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_md_r    <= mag - db_q30;
      s2_side_r  <= s1_side_r;
      s2_pneg_r  <= s1_prod_r[33];   // negative product means positive after inversion
      s2_coast_r <= s2_coast_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: (m - db) * span
  // ---------------------------------------------------------------------------
  logic signed [42:0] s3_prod_r;
  logic               s3_side_r, s3_pneg_r, s3_coast_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_prod_r  <= $signed({1'b0, s2_md_r}) * span;
      s3_side_r  <= s2_side_r;
      s3_pneg_r  <= s2_pneg_r;
      s3_coast_r <= s2_coast_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: t = min * den + (m - db) * span, floored at zero
  // ---------------------------------------------------------------------------
  logic signed [42:0] t_sum;
  logic [39:0]        s4_t_r;
  logic               s4_side_r, s4_pneg_r, s4_coast_r;

  assign t_sum = $signed({2'b0, mind_r, 16'b0}) + s3_prod_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_t_r     <= t_sum[42] ? '0 : t_sum[39:0];
      s4_side_r  <= s3_side_r;
      s4_pneg_r  <= s3_pneg_r;
      s4_coast_r <= s3_coast_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: add half a divisor and drop the 2^16 factor of den
  // ---------------------------------------------------------------------------
  logic [40:0]    t_rnd;
  logic [N_W-1:0] s5_n_r;
  logic           s5_side_r, s5_pneg_r, s5_coast_r;

  assign t_rnd = {1'b0, s4_t_r} + {11'b0, den_q, 15'b0};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_n_r     <= t_rnd[39:16];
      s5_side_r  <= s4_side_r;
      s5_pneg_r  <= s4_pneg_r;
      s5_coast_r <= s4_coast_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 6..15: restoring divide by den_q, msb of quotient first
  // ---------------------------------------------------------------------------
  logic [N_W-1:0]   div_rem_r  [DIV_STEPS];
  logic [PWM_W-1:0] div_q_r    [DIV_STEPS];
  logic             div_side_r [DIV_STEPS];
  logic             div_pneg_r [DIV_STEPS];
  logic             div_coast_r[DIV_STEPS];
  logic [N_W-1:0]   div_rem_src[DIV_STEPS];
  logic [PWM_W-1:0] div_q_src  [DIV_STEPS];
  logic [N_W:0]     div_trial  [DIV_STEPS];
  logic [N_W-1:0]   div_rem_nxt[DIV_STEPS];
  logic [PWM_W-1:0] div_q_nxt  [DIV_STEPS];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      div_rem_src[j] = (j == 0) ? s5_n_r : div_rem_r[(j == 0) ? 0 : j-1];
      div_q_src[j]   = (j == 0) ? '0     : div_q_r[(j == 0) ? 0 : j-1];
      div_trial[j]   = {1'b0, div_rem_src[j]}
                     - ({{(N_W-DB_W){1'b0}}, den_q} << (DIV_STEPS - 1 - j));
      if (!div_trial[j][N_W]) begin
        div_rem_nxt[j] = div_trial[j][N_W-1:0];
        div_q_nxt[j]   = div_q_src[j] | (PWM_W'(1) << (DIV_STEPS - 1 - j));
      end else begin
        div_rem_nxt[j] = div_rem_src[j];
        div_q_nxt[j]   = div_q_src[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en[FRONT + j]) begin
        div_rem_r[j] <= div_rem_nxt[j];
        div_q_r[j]   <= div_q_nxt[j];
        if (j == 0) begin
          div_side_r[j]  <= s5_side_r;
          div_pneg_r[j]  <= s5_pneg_r;
          div_coast_r[j] <= s5_coast_r;
        end else begin
          div_side_r[j]  <= div_side_r[(j == 0) ? 0 : j-1];
          div_pneg_r[j]  <= div_pneg_r[(j == 0) ? 0 : j-1];
          div_coast_r[j] <= div_coast_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 16: clamp to max_pwm, coast and bridge direction
  // ---------------------------------------------------------------------------
  logic [PWM_W-1:0] q_fin;
  logic [PWM_W-1:0] pwm_nxt;
  logic             drive_on;
  logic             side_r, in1_r, in2_r;
  logic [PWM_W-1:0] pwm_r;

  assign q_fin = div_q_r[DIV_STEPS-1];

  always_comb begin
    if (div_coast_r[DIV_STEPS-1]) begin
      pwm_nxt = '0;
    end else if (q_fin > max_pwm_r) begin
      pwm_nxt = max_pwm_r;
    end else begin
      pwm_nxt = q_fin;
    end
  end

  assign drive_on = (pwm_nxt != '0);

  always_ff @(posedge clk) begin
    if (en[NSTAGE-1]) begin
      side_r <= div_side_r[DIV_STEPS-1];
      pwm_r  <= pwm_nxt;
      in1_r  <= drive_on && !div_pneg_r[DIV_STEPS-1];
      in2_r  <= drive_on && div_pneg_r[DIV_STEPS-1];
    end
  end

  assign out_side      = side_r;
  assign out_drive_in1 = in1_r;
  assign out_drive_in2 = in2_r;
  assign out_pwm_value = pwm_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `HBDP_ASSERT_NOW(a_coast_low, out_valid && (out_pwm_value == '0),
    !out_drive_in1 && !out_drive_in2, "coast result drives a bridge input")
  `HBDP_ASSERT_NOW(a_one_side, out_valid && (out_pwm_value != '0),
    out_drive_in1 != out_drive_in2, "driven result needs exactly one bridge input high")
  `HBDP_ASSERT_NEXT(a_enter, in_valid && !in_stall, vld_r[0],
    "accepted transaction missing from first stage")

endmodule
